[rtl/rtcs_pkg.sv]
`default_nettype none

package rtcs_pkg;

	// Relocation entry types
	localparam logic [3:0] TypeDir64    = 4'd10;
	localparam logic [3:0] TypeAbsolute = 4'd0;

	// Bytes covered by one 64-bit fixup
	localparam logic [33:0] CoverBytes = 34'd8;

	// Smallest legal block size (header only)
	localparam logic [31:0] MinBlockSize = 32'd8;

	// Header length in halfwords, taken off the halved block size
	localparam logic [30:0] HeaderHalfwords = 31'd4;

	// Where the scan stands within a block
	typedef enum logic [2:0] {
		PH_BASE_LO = 3'd0,
		PH_BASE_HI = 3'd1,
		PH_SIZE_LO = 3'd2,
		PH_SIZE_HI = 3'd3,
		PH_ENTRY   = 3'd4
	} phase_t;

	// Full scan state carried from one halfword to the next
	typedef struct packed {
		phase_t       phase;
		logic [31:0]  base;
		logic [15:0]  size_lo;
		logic [30:0]  left;
		logic         hit;
		logic         type_err;
		logic         malf;
		logic         fin;
	} scan_state_t;

	// One accepted halfword with its markers
	typedef struct packed {
		logic [15:0] halfword;
		logic        first_word;
		logic        last_word;
	} scan_item_t;

endpackage

`default_nettype wire

[rtl/rtcs_step.sv]
`default_nettype none

module rtcs_step (
	input  wire rtcs_pkg::scan_state_t cur,
	input  wire rtcs_pkg::scan_item_t  item,
	input  wire [32:0]                 query,
	output rtcs_pkg::scan_state_t      nxt
);

	rtcs_pkg::scan_state_t start_st;
	logic [3:0]  ent_type;
	logic [32:0] ent_start;
	logic [33:0] ent_end;
	logic        ent_hit;
	logic [31:0] blk_size;
	logic [30:0] blk_left;
	logic [30:0] left_dec;

	// A new scan starts from the reset state
	always_comb begin
		if (item.first_word) begin
			start_st       = '0;
			start_st.phase = rtcs_pkg::PH_BASE_LO;
		end else begin
			start_st = cur;
		end
	end

	// Entry decode and cover window compare
	assign ent_type  = item.halfword[15:12];
	assign ent_start = {1'b0, start_st.base} + {21'b0, item.halfword[11:0]};
	assign ent_end   = {1'b0, ent_start} + rtcs_pkg::CoverBytes;
	assign ent_hit   = (ent_start <= query) && ({1'b0, query} < ent_end);
	assign left_dec  = start_st.left - 31'd1;

	// Block size and entry count
	assign blk_size = {item.halfword, start_st.size_lo};
	assign blk_left = blk_size[31:1] - rtcs_pkg::HeaderHalfwords;

	// Phase update for one halfword
	always_comb begin
		nxt = start_st;
		if (!start_st.fin) begin
			case (start_st.phase)
				rtcs_pkg::PH_BASE_HI: begin
					nxt.base[31:16] = item.halfword;
					nxt.phase       = rtcs_pkg::PH_SIZE_LO;
				end
				rtcs_pkg::PH_SIZE_LO: begin
					nxt.size_lo = item.halfword;
					nxt.phase   = rtcs_pkg::PH_SIZE_HI;
				end
				rtcs_pkg::PH_SIZE_HI: begin
					if ((blk_size < rtcs_pkg::MinBlockSize) || blk_size[0]) begin
						nxt.malf = 1'b1;
						nxt.fin  = 1'b1;
					end else begin
						nxt.left  = blk_left;
						// empty block goes straight to the next header
						nxt.phase = (blk_left == '0) ? rtcs_pkg::PH_BASE_LO
						                             : rtcs_pkg::PH_ENTRY;
					end
				end
				rtcs_pkg::PH_ENTRY: begin
					if (ent_type == rtcs_pkg::TypeDir64) begin
						if (ent_hit) begin
							nxt.hit = 1'b1;
							nxt.fin = 1'b1;
						end
					end else if (ent_type != rtcs_pkg::TypeAbsolute) begin
						nxt.type_err = 1'b1;
						nxt.fin      = 1'b1;
					end
					nxt.left = left_dec;
					if (left_dec == '0) begin
						nxt.phase = rtcs_pkg::PH_BASE_LO;
					end
				end
				default: begin
					// base low half; unused codes land here too
					nxt.base  = {16'b0, item.halfword};
					nxt.phase = rtcs_pkg::PH_BASE_HI;
				end
			endcase
			if (item.last_word) begin
				nxt.fin = 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/reloc_table_cover_scan.sv]
`default_nettype none

// Channel   Dir  Handshake                Payload
// in        in   in_valid / in_stall      halfword, first_word, last_word
// out       out  out_valid / out_stall    covered, bad_type, malformed, scan_done
// cfg       in   cfg_valid / cfg_ready    query_address
//
// One halfword per cycle sustained while out_stall is low. Each transferred
// halfword loads the input register; the scan step then loads its result into
// the result register that drives the outputs; the scan state updates with it.
// arst_n clears the scan state, the query address and both valid flags.
// out_stall holds a valid result register and, through it, the input register;
// in_stall rises only while the input register is full and cannot move on.

module reloc_table_cover_scan (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [15:0] halfword,
	input  wire         first_word,
	input  wire         last_word,
	output logic        out_valid,
	input  wire         out_stall,
	output logic        covered,
	output logic        bad_type,
	output logic        malformed,
	output logic        scan_done,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [32:0] query_address
);

	rtcs_pkg::scan_item_t  item_s1;
	logic                  valid_s1;
	rtcs_pkg::scan_state_t state_q;
	rtcs_pkg::scan_state_t state_nxt;
	logic [32:0]           query_q;
	logic                  out_valid_q;
	logic [3:0]            flags_q;
	logic                  adv_s1;
	logic                  in_xfer;

	assign cfg_ready = 1'b1;

	// Pipeline control
	assign adv_s1   = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv_s1;
	assign in_xfer  = in_valid && !in_stall;

	// Query register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			query_q <= query_address;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1 || !valid_s1) begin
			valid_s1 <= in_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1 <= '{halfword: halfword, first_word: first_word, last_word: last_word};
		end
	end

	// Scan step
	rtcs_step u_step (
		.cur   (state_q),
		.item  (item_s1),
		.query (query_q),
		.nxt   (state_nxt)
	);

	// Scan state and result register; an all-zero state is base low half
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= '0;
			out_valid_q   <= 1'b0;
			flags_q       <= '0;
		end else if (adv_s1) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
				flags_q <= {state_nxt.hit, state_nxt.type_err, state_nxt.malf, state_nxt.fin};
			end
		end
	end

	assign out_valid = out_valid_q;
	assign covered   = flags_q[3];
	assign bad_type  = flags_q[2];
	assign malformed = flags_q[1];
	assign scan_done = flags_q[0];

	// Any latched flag ends the scan
	a_hit_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (covered || bad_type || malformed) |-> scan_done)
		else $error("flag without scan_done");

	// Stall only with a full input register
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("stall with empty input register");

	// Finished scan without restart keeps the state
	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && valid_s1 && state_q.fin && !item_s1.first_word |=>
		$stable(state_q))
		else $error("finished scan state changed");

endmodule

`default_nettype wire

[verif/tb.sv]
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Latched flags of one scan result
	typedef struct packed {
		bit covered;
		bit bad_type;
		bit malformed;
		bit scan_done;
	} scan_flags_t;

	// Relocation scan predictor plus the queue of flags still to come out
	class flag_scoreboard;
		rtcs_pkg::phase_t phase;
		logic [31:0] base;
		logic [15:0] size_lo;
		logic [30:0] left;
		bit          hit, type_err, malf, fin;
		logic [32:0] query;
		scan_flags_t expected_q[$];
		int          errors, results_checked, halfwords_seen, scans;
		int          hits, type_errs, malf_sizes, query_writes;

		function new();
			phase   = rtcs_pkg::PH_BASE_LO;
			base    = '0;
			size_lo = '0;
			left    = '0;
			query   = '0;
		endfunction

		task flag_mismatch(input string msg);
			$display("ERROR @%0t: %s", $realtime, msg);
			errors++;
		endtask

		function void set_query(input logic [32:0] q);
			query = q;
			query_writes++;
		endfunction

		// One halfword transfer in: advance the scan and queue its flags
		function void note_halfword(input logic [15:0] hw, input bit is_first,
				input bit is_last);
			logic [31:0] size;
			logic [33:0] start;
			scan_flags_t want;
			halfwords_seen++;
			if (is_first) begin
				phase    = rtcs_pkg::PH_BASE_LO;
				base     = '0;
				size_lo  = '0;
				left     = '0;
				hit      = 0;
				type_err = 0;
				malf     = 0;
				fin      = 0;
				scans++;
			end
			if (!fin) begin
				case (phase)
					rtcs_pkg::PH_BASE_HI: begin
						base[31:16] = hw;
						phase = rtcs_pkg::PH_SIZE_LO;
					end
					rtcs_pkg::PH_SIZE_LO: begin
						size_lo = hw;
						phase = rtcs_pkg::PH_SIZE_HI;
					end
					rtcs_pkg::PH_SIZE_HI: begin
						size = {hw, size_lo};
						if (size < 32'd8 || size[0]) begin
							malf = 1;
							fin  = 1;
							malf_sizes++;
						end else begin
							// header is four halfwords
							left  = size[31:1] - 31'd4;
							phase = (left == '0) ? rtcs_pkg::PH_BASE_LO : rtcs_pkg::PH_ENTRY;
						end
					end
					rtcs_pkg::PH_ENTRY: begin
						// 34-bit window so nothing wraps
						start = {2'b00, base} + {22'd0, hw[11:0]};
						if (hw[15:12] == rtcs_pkg::TypeDir64) begin
							if (start <= {1'b0, query} && {1'b0, query} < start + 34'd8) begin
								hit = 1;
								fin = 1;
								hits++;
							end
						end else if (hw[15:12] != rtcs_pkg::TypeAbsolute) begin
							type_err = 1;
							fin = 1;
							type_errs++;
						end
						left = left - 31'd1;
						if (left == '0) begin
							phase = rtcs_pkg::PH_BASE_LO;
						end
					end
					default: begin
						base  = {16'h0000, hw};
						phase = rtcs_pkg::PH_BASE_HI;
					end
				endcase
				if (is_last) begin
					fin = 1;
				end
			end
			want.covered   = hit;
			want.bad_type  = type_err;
			want.malformed = malf;
			want.scan_done = fin;
			expected_q.push_back(want);
		endfunction

		// One result transfer out: compare against the oldest expectation
		task check_flags(input logic c, input logic b, input logic m, input logic d);
			scan_flags_t want;
			if (expected_q.size() == 0) begin
				flag_mismatch("result transfer with no halfword outstanding");
				return;
			end
			want = expected_q.pop_front();
			results_checked++;
			if (c !== want.covered)
				flag_mismatch($sformatf("result %0d covered %b, want %b",
					results_checked, c, want.covered));
			if (b !== want.bad_type)
				flag_mismatch($sformatf("result %0d bad_type %b, want %b",
					results_checked, b, want.bad_type));
			if (m !== want.malformed)
				flag_mismatch($sformatf("result %0d malformed %b, want %b",
					results_checked, m, want.malformed));
			if (d !== want.scan_done)
				flag_mismatch($sformatf("result %0d scan_done %b, want %b",
					results_checked, d, want.scan_done));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [15:0] halfword;
	logic        first_word;
	logic        last_word;
	logic        out_valid;
	logic        out_stall;
	logic        covered;
	logic        bad_type;
	logic        malformed;
	logic        scan_done;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [32:0] query_address;

	int send_idle_pct;
	int recv_idle_pct;

	flag_scoreboard board = new();

	reloc_table_cover_scan uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.halfword      (halfword),
		.first_word    (first_word),
		.last_word     (last_word),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.covered       (covered),
		.bad_type      (bad_type),
		.malformed     (malformed),
		.scan_done     (scan_done),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.query_address (query_address)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Random backpressure on the result side
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	// Transfer monitor, sampled at the clock edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				board.note_halfword(halfword, first_word, last_word);
			if (out_valid && !out_stall)
				board.check_flags(covered, bad_type, malformed, scan_done);
		end
	end

	// Drive one halfword, with optional idle cycles ahead of it
	task automatic send_halfword(input logic [15:0] hw, input logic is_first,
			input logic is_last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		halfword   <= hw;
		first_word <= is_first;
		last_word  <= is_last;
		do @(posedge clk); while (in_stall);
	endtask

	// Hold off the sender until every queued result has been checked
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (board.expected_q.size() != 0);
	endtask

	task automatic write_query(input logic [32:0] q);
		cfg_valid     <= 1'b1;
		query_address <= q;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.set_query(q);
	endtask

	// One random directory: mostly well-formed blocks aimed near the query,
	// some noise, truncation and stray scan starts
	task automatic send_directory(input logic [32:0] q);
		logic [15:0] words[$];
		logic [31:0] base, size;
		logic [33:0] diff;
		logic [3:0]  ty;
		int          nblk, nent, sel, stray, last_idx;
		bit          put_last;
		words.delete();
		if ($urandom_range(0, 99) < 10) begin
			// pure noise
			nblk = $urandom_range(1, 10);
			for (int i = 0; i < nblk; i++)
				words.push_back(16'($urandom));
		end else begin
			nblk = $urandom_range(1, 4);
			for (int b = 0; b < nblk; b++) begin
				if ($urandom_range(0, 9) < 7)
					base = q[31:0] - $urandom_range(0, 32'h1007);
				else
					base = $urandom;
				nent = $urandom_range(0, 6);
				sel  = $urandom_range(0, 99);
				if (sel < 4)
					size = $urandom_range(0, 7);
				else if (sel < 8)
					size = $urandom | 32'd1;
				else if (sel < 11)
					size = $urandom & ~32'd1;
				else
					size = 32'd8 + 32'(2 * nent);
				words.push_back(base[15:0]);
				words.push_back(base[31:16]);
				words.push_back(size[15:0]);
				words.push_back(size[31:16]);
				for (int e = 0; e < nent; e++) begin
					sel = $urandom_range(0, 99);
					if (sel < 60)
						ty = rtcs_pkg::TypeDir64;
					else if (sel < 90)
						ty = rtcs_pkg::TypeAbsolute;
					else
						ty = 4'($urandom);
					diff = {1'b0, q} - {2'b00, base} - 34'($urandom_range(0, 7));
					if (ty == rtcs_pkg::TypeDir64 && $urandom_range(0, 3) == 0
							&& diff < 34'h1000)
						words.push_back({ty, diff[11:0]});
					else
						words.push_back({ty, 12'($urandom)});
				end
			end
			// broken sequence: cut short somewhere
			if ($urandom_range(0, 99) < 10) begin
				nent = $urandom_range(1, words.size());
				while (words.size() > nent)
					void'(words.pop_back());
			end
		end
		last_idx = words.size() - 1;
		put_last = ($urandom_range(0, 99) < 92);
		stray    = ($urandom_range(0, 99) < 5) ? $urandom_range(1, words.size()) : -1;
		for (int i = 0; i <= last_idx; i++)
			send_halfword(words[i], (i == 0) || (i == stray), (i == last_idx) && put_last);
	endtask

	initial begin
		logic [32:0] settings[6];
		int          goal;

		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		halfword      <= '0;
		first_word    <= 1'b0;
		last_word     <= 1'b0;
		cfg_valid     <= 1'b0;
		query_address <= '0;
		out_stall     <= 1'b0;
		send_idle_pct = 36;
		recv_idle_pct = 64;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: query on the last byte of the highest 33-bit window
		write_query(33'h1_0000_1005);
		// base FFFFFFFF, three entries: miss, pad, hit at offset FFF
		send_halfword(16'hFFFF, 1'b1, 1'b0);
		send_halfword(16'hFFFF, 1'b0, 1'b0);
		send_halfword(16'h000E, 1'b0, 1'b0);
		send_halfword(16'h0000, 1'b0, 1'b0);
		send_halfword(16'hA000, 1'b0, 1'b0);
		send_halfword(16'h0000, 1'b0, 1'b0);
		send_halfword(16'hAFFF, 1'b0, 1'b0);
		// ignored after the scan ended
		send_halfword(16'hFFFF, 1'b0, 1'b0);
		// empty block, then a size below the header
		send_halfword(16'h1000, 1'b1, 1'b0);
		send_halfword(16'h0000, 1'b0, 1'b0);
		send_halfword(16'h0008, 1'b0, 1'b0);
		send_halfword(16'h0000, 1'b0, 1'b0);
		send_halfword(16'h0000, 1'b0, 1'b0);
		send_halfword(16'h0000, 1'b0, 1'b0);
		send_halfword(16'h0007, 1'b0, 1'b0);
		send_halfword(16'h0000, 1'b0, 1'b0);
		// odd size
		send_halfword(16'h0000, 1'b1, 1'b0);
		send_halfword(16'h0000, 1'b0, 1'b0);
		send_halfword(16'h0011, 1'b0, 1'b0);
		send_halfword(16'h0000, 1'b0, 1'b0);
		// one entry with an unknown type
		send_halfword(16'h0000, 1'b1, 1'b0);
		send_halfword(16'h0000, 1'b0, 1'b0);
		send_halfword(16'h000A, 1'b0, 1'b0);
		send_halfword(16'h0000, 1'b0, 1'b0);
		send_halfword(16'h5123, 1'b0, 1'b0);
		// start and last word together, mid-block
		send_halfword(16'h0000, 1'b1, 1'b1);
		drain_results();

		// Random phases, each with its own query setting
		settings[0] = 33'h0_0000_0000;
		settings[1] = 33'h1_FFFF_FFFF;
		settings[2] = {1'($urandom), 32'($urandom)};
		settings[3] = 33'h0_FFFF_FFFF;
		settings[4] = {1'b0, 32'($urandom)};
		settings[5] = {1'($urandom), 32'($urandom)};
		for (int ph = 0; ph < 6; ph++) begin
			case (ph / 2)
				0: begin
					send_idle_pct = 36;
					recv_idle_pct = 64;
				end
				1: begin
					send_idle_pct = 64;
					recv_idle_pct = 36;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			write_query(settings[ph]);
			goal = board.halfwords_seen + 125;
			while (board.halfwords_seen < goal)
				send_directory(board.query);
			drain_results();
		end

		repeat (8) @(posedge clk);
		if (board.expected_q.size() != 0)
			board.flag_mismatch($sformatf("%0d results never arrived", board.expected_q.size()));

		$display("Scanned %0d directories, %0d results checked, %0d query settings",
			board.scans, board.results_checked, board.query_writes);
		$display("Scans ended by hit: %0d, bad type: %0d, malformed size: %0d",
			board.hits, board.type_errs, board.malf_sizes);
		if (board.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire

[sim.f]
rtl/rtcs_pkg.sv
rtl/rtcs_step.sv
rtl/reloc_table_cover_scan.sv
verif/tb.sv
